>>> hw/rtl/rhc_pkg.sv
package rhc_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned HUE_W   = 9;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned NUM_W   = 17;
  localparam int unsigned Q_W     = 9;
  localparam int unsigned LANES   = 3;
  localparam int unsigned DIV_STG = Q_W;

  localparam int unsigned LN_HUE = 0;
  localparam int unsigned LN_HSV = 1;
  localparam int unsigned LN_HSL = 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [Q_W-1:0]   quo_t;

endpackage

>>> hw/rtl/rhc_if.sv
interface rhc_pix_if;
  logic          valid;
  logic          ready;
  rhc_pkg::pix_t red;
  rhc_pkg::pix_t green;
  rhc_pkg::pix_t blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_res_if;
  logic                         valid;
  logic                         ready;
  logic [rhc_pkg::HUE_W-1:0]    hue_degrees;
  logic [rhc_pkg::PCT_W-1:0]    hsv_saturation_pct;
  logic [rhc_pkg::PCT_W-1:0]    value_pct;
  logic [rhc_pkg::PCT_W-1:0]    hsl_saturation_pct;
  logic [rhc_pkg::PCT_W-1:0]    lightness_pct;
  modport source (output valid, output hue_degrees, output hsv_saturation_pct,
                  output value_pct, output hsl_saturation_pct, output lightness_pct,
                  input ready);
  modport sink   (input valid, input hue_degrees, input hsv_saturation_pct,
                  input value_pct, input hsl_saturation_pct, input lightness_pct,
                  output ready);
endinterface

>>> hw/rtl/rgb_to_hsv_hsl_converter.sv
// An input transaction reaches the result through the min/max stage, the
// numerator stage and nine restoring divider stages, one quotient bit each.
// Throughput: one pixel per cycle unless the output stalls; the nine-stage divider
// pipeline sets depth. A stall at the output freezes the whole pipeline; nothing is lost.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module rgb_to_hsv_hsl_converter (
  input  logic       clk,
  input  logic       rst_n,
  rhc_pix_if.sink    in_pix,
  rhc_res_if.source  out_res
);

  logic en;

  // stage 1: max / min
  logic          s1_vld_r;
  rhc_pkg::pix_t r1_r, g1_r, b1_r, mx1_r, mn1_r;
  rhc_pkg::pix_t mx_nxt, mn_nxt;

  // divider pipeline, index 0 loaded by numerator stage
  logic          st_vld_r [0:rhc_pkg::DIV_STG];
  rhc_pkg::num_t rem_r    [0:rhc_pkg::DIV_STG][0:rhc_pkg::LANES-1];
  rhc_pkg::pix_t dv_r     [0:rhc_pkg::DIV_STG][0:rhc_pkg::LANES-1];
  rhc_pkg::quo_t q_r      [0:rhc_pkg::DIV_STG][0:rhc_pkg::LANES-1];

  // value and lightness, divided by 255 in the numerator stage, delayed alongside
  logic [rhc_pkg::PCT_W-1:0] val_r [0:rhc_pkg::DIV_STG];
  logic [rhc_pkg::PCT_W-1:0] lig_r [0:rhc_pkg::DIV_STG];
  logic [rhc_pkg::PCT_W-1:0] val_nxt, lig_nxt;

  rhc_pkg::num_t num_nxt  [0:rhc_pkg::LANES-1];
  rhc_pkg::pix_t dvs_nxt  [0:rhc_pkg::LANES-1];

  assign en           = !st_vld_r[rhc_pkg::DIV_STG] || out_res.ready;
  assign in_pix.ready = en;

  always_comb begin
    mx_nxt = in_pix.red;
    mn_nxt = in_pix.red;
    if (in_pix.green > mx_nxt) mx_nxt = in_pix.green;
    if (in_pix.blue  > mx_nxt) mx_nxt = in_pix.blue;
    if (in_pix.green < mn_nxt) mn_nxt = in_pix.green;
    if (in_pix.blue  < mn_nxt) mn_nxt = in_pix.blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_pix.valid;
    end
    if (en) begin
      r1_r  <= in_pix.red;
      g1_r  <= in_pix.green;
      b1_r  <= in_pix.blue;
      mx1_r <= mx_nxt;
      mn1_r <= mn_nxt;
    end
  end

  // stage 2: numerators and divisors; a zero divisor becomes one (numerator is zero then)
  always_comb begin
    logic [rhc_pkg::PIX_W-1:0] d;
    logic [rhc_pkg::PIX_W:0]   sum;
    logic [rhc_pkg::PIX_W-1:0] den;
    rhc_pkg::num_t             d17;
    logic [15:0]               vx, vt, lx, lt;
    d   = mx1_r - mn1_r;
    sum = {1'b0, mx1_r} + {1'b0, mn1_r};
    den = (sum >= 9'd255) ? rhc_pkg::PIX_W'(9'd510 - sum) : sum[rhc_pkg::PIX_W-1:0];
    d17 = rhc_pkg::NUM_W'(d);

    if (mx1_r == r1_r) begin
      if (g1_r < b1_r) num_nxt[rhc_pkg::LN_HUE] =
          17'd360 * d17 - 17'd60 * rhc_pkg::NUM_W'(b1_r - g1_r);
      else num_nxt[rhc_pkg::LN_HUE] = 17'd60 * rhc_pkg::NUM_W'(g1_r - b1_r);
    end else if (mx1_r == g1_r) begin
      if (b1_r >= r1_r) num_nxt[rhc_pkg::LN_HUE] =
          17'd120 * d17 + 17'd60 * rhc_pkg::NUM_W'(b1_r - r1_r);
      else num_nxt[rhc_pkg::LN_HUE] =
          17'd120 * d17 - 17'd60 * rhc_pkg::NUM_W'(r1_r - b1_r);
    end else begin
      if (r1_r >= g1_r) num_nxt[rhc_pkg::LN_HUE] =
          17'd240 * d17 + 17'd60 * rhc_pkg::NUM_W'(r1_r - g1_r);
      else num_nxt[rhc_pkg::LN_HUE] =
          17'd240 * d17 - 17'd60 * rhc_pkg::NUM_W'(g1_r - r1_r);
    end
    dvs_nxt[rhc_pkg::LN_HUE] = (d == '0) ? 8'd1 : d;

    num_nxt[rhc_pkg::LN_HSV] = 17'd100 * d17;
    dvs_nxt[rhc_pkg::LN_HSV] = (mx1_r == '0) ? 8'd1 : mx1_r;
    num_nxt[rhc_pkg::LN_HSL] = 17'd100 * d17;
    dvs_nxt[rhc_pkg::LN_HSL] = (den == '0) ? 8'd1 : den;

    // x/255 == (x + (x >> 8) + 1) >> 8 for x below 65535
    vx      = 16'd100 * 16'(mx1_r);
    vt      = vx + {8'd0, vx[15:8]} + 16'd1;
    val_nxt = vt[8 +: rhc_pkg::PCT_W];
    // 100*sum/510 == 50*sum/255
    lx      = 16'd50 * 16'(sum);
    lt      = lx + {8'd0, lx[15:8]} + 16'd1;
    lig_nxt = lt[8 +: rhc_pkg::PCT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r[0] <= 1'b0;
    end else if (en) begin
      st_vld_r[0] <= s1_vld_r;
    end
    if (en) begin
      val_r[0] <= val_nxt;
      lig_r[0] <= lig_nxt;
      for (int l = 0; l < rhc_pkg::LANES; l++) begin
        rem_r[0][l] <= num_nxt[l];
        dv_r[0][l]  <= dvs_nxt[l];
        q_r[0][l]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar s = 0; s < rhc_pkg::DIV_STG; s++) begin : g_div
    localparam int unsigned BIT = rhc_pkg::Q_W - 1 - s;
    rhc_pkg::num_t rem_nxt [0:rhc_pkg::LANES-1];
    rhc_pkg::quo_t q_nxt   [0:rhc_pkg::LANES-1];

    always_comb begin
      for (int l = 0; l < rhc_pkg::LANES; l++) begin
        rhc_pkg::num_t sh;
        sh         = rhc_pkg::NUM_W'(dv_r[s][l]) << BIT;
        rem_nxt[l] = rem_r[s][l];
        q_nxt[l]   = q_r[s][l];
        if (rem_r[s][l] >= sh) begin
          rem_nxt[l]    = rem_r[s][l] - sh;
          q_nxt[l][BIT] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        st_vld_r[s+1] <= st_vld_r[s];
      end
      if (en) begin
        val_r[s+1] <= val_r[s];
        lig_r[s+1] <= lig_r[s];
        for (int l = 0; l < rhc_pkg::LANES; l++) begin
          rem_r[s+1][l] <= rem_nxt[l];
          dv_r[s+1][l]  <= dv_r[s][l];
          q_r[s+1][l]   <= q_nxt[l];
        end
      end
    end
  end

  assign out_res.valid              = st_vld_r[rhc_pkg::DIV_STG];
  assign out_res.hue_degrees        = q_r[rhc_pkg::DIV_STG][rhc_pkg::LN_HUE];
  assign out_res.hsv_saturation_pct =
      q_r[rhc_pkg::DIV_STG][rhc_pkg::LN_HSV][rhc_pkg::PCT_W-1:0];
  assign out_res.value_pct          = val_r[rhc_pkg::DIV_STG];
  assign out_res.hsl_saturation_pct =
      q_r[rhc_pkg::DIV_STG][rhc_pkg::LN_HSL][rhc_pkg::PCT_W-1:0];
  assign out_res.lightness_pct      = lig_r[rhc_pkg::DIV_STG];

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> s1_vld_r)
    else $error("accepted transaction did not enter the pipeline");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.hue_degrees < 9'd360 && out_res.value_pct <= 7'd100 &&
      out_res.hsv_saturation_pct <= 7'd100 && out_res.hsl_saturation_pct <= 7'd100)
    else $error("result out of range");

  a_light_le_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> out_res.lightness_pct <= out_res.value_pct)
    else $error("lightness exceeds value");

endmodule
